>>> rtl/lsh_pkg.sv
// shared types and constants for the 3x3 laplacian sharpen block
`default_nettype none
package lsh_pkg;

  localparam int CFG_W        = 12;
  localparam int KERNEL_GAIN  = 5;
  localparam int PIX_MAX      = 255;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [7:0] pixel_t;

  typedef struct packed {
    logic produce;
    logic interior;
    logic last_row;
    logic last_col;
  } lsh_flags_t;

  typedef struct packed {
    pixel_t upper_pixel;
    pixel_t bottom_row_pixel;
    logic   bottom_row_valid;
    logic   frame_done;
  } lsh_result_t;

endpackage
`default_nettype wire

>>> rtl/lsh_if.sv
// valid/ready stream interfaces for pixel input and result output
`default_nettype none
interface lsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lsh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] upper_pixel;
  logic [7:0] bottom_row_pixel;
  logic       bottom_row_valid;
  logic       frame_done;

  modport source (output valid, output upper_pixel, output bottom_row_pixel,
                  output bottom_row_valid, output frame_done, input ready);
  modport sink   (input valid, input upper_pixel, input bottom_row_pixel,
                  input bottom_row_valid, input frame_done, output ready);
endinterface
`default_nettype wire

>>> rtl/lsh_kernel.sv
// cross-kernel sharpen arithmetic with saturation and border pass-through
`default_nettype none
module lsh_kernel (
  input  wire lsh_pkg::lsh_flags_t  flags,
  input  wire lsh_pkg::pixel_t      above,
  input  wire lsh_pkg::pixel_t      above2,
  input  wire lsh_pkg::pixel_t      left,
  input  wire lsh_pkg::pixel_t      right,
  input  wire lsh_pkg::pixel_t      px,
  output lsh_pkg::lsh_result_t      res
);
  import lsh_pkg::*;

  logic [10:0]        gained;
  logic [9:0]         ring;
  logic signed [11:0] v;
  pixel_t             sharp;

  always_comb begin
    gained = 11'(above) * 11'(KERNEL_GAIN);
    ring   = 10'(above2) + 10'(left) + 10'(right) + 10'(px);
    v      = $signed({1'b0, gained}) - $signed({2'b00, ring});
    if (v < 0) begin
      sharp = '0;
    end else if (v > 12'sd255) begin
      sharp = 8'(PIX_MAX);
    end else begin
      sharp = v[7:0];
    end

    res.upper_pixel      = flags.interior ? sharp : above;
    res.bottom_row_pixel = flags.last_row ? px : '0;
    res.bottom_row_valid = flags.last_row;
    res.frame_done       = flags.last_row & flags.last_col;
  end

endmodule
`default_nettype wire

>>> rtl/laplacian_sharpen_3x3.sv
// 3x3 cross-kernel laplacian sharpen over a raster pixel stream
//
// pix_in carries one grayscale pixel per beat in raster order; the frame
// restarts after image_width*image_height beats. res_out carries one beat for
// every input pixel outside the first row: the finished pixel one row above,
// same column, plus a copy of the input while it lies in the last row, and
// frame_done on the last pixel of the frame.
// image_width (addr 0) and image_height (addr 4) are set over the apb port
// while the stream is idle.
// throughput is one pixel per clock while the receiver does not stall; an accepted
// beat passes the input register and the line-store read, then the result
// register. the previous-row store is read at two columns per beat.
// reset clears the position counters and the pipeline valids; the line stores
// keep whatever they held and are refilled by the first rows of a frame.
// when the receiver stalls, the result register holds and the input register
// takes one more beat before pix_in.ready drops.
`default_nettype none
module laplacian_sharpen_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  lsh_in_if.sink     pix_in,
  lsh_out_if.source  res_out
);
  import lsh_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int RW = CFG_W + 1;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  logic [CW-1:0]    col;
  logic [CFG_W-1:0] row;

  logic [EW-1:0]    eff_w;
  logic [CFG_W-1:0] eff_h;
  logic             wrap_c;
  logic [CW-1:0]    cn;
  logic [CW-1:0]    cn_r;
  logic [EW-1:0]    cn_ext;
  logic [EW-1:0]    cn1;
  logic [RW-1:0]    row_pre;
  logic [CFG_W-1:0] rn;
  logic [RW-1:0]    rn1;
  logic             col_end;
  logic [CW-1:0]    col_next;
  logic [CFG_W-1:0] row_next;
  lsh_flags_t       flags_next;

  logic             acc;
  logic             s1_valid;
  logic             s1_go;
  pixel_t           s1_px;
  logic [CW-1:0]    s1_col;
  lsh_flags_t       s1_flags;
  pixel_t           win_center;

  pixel_t           prev_row [MAX_WIDTH];
  pixel_t           prev2_row [MAX_WIDTH];
  pixel_t           above_rd;
  pixel_t           right_rd;
  pixel_t           above2_rd;
  logic             sp_byp;
  pixel_t           sp_byp_data;
  pixel_t           above2;

  logic             out_valid;
  lsh_result_t      out_res;
  lsh_result_t      res;

  logic             cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  // position of the incoming beat
  always_comb begin
    if (EW'(image_width) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else if (image_width == '0) begin
      eff_w = EW'(1);
    end else begin
      eff_w = EW'(image_width);
    end
    eff_h = (image_height == '0) ? CFG_W'(1) : image_height;

    wrap_c  = EW'(col) >= eff_w;
    cn      = wrap_c ? '0 : col;
    cn_r    = cn + CW'(1);
    cn_ext  = EW'(cn);
    cn1     = cn_ext + EW'(1);
    row_pre = wrap_c ? RW'(row) + RW'(1) : RW'(row);
    rn      = (row_pre >= RW'(eff_h)) ? '0 : row_pre[CFG_W-1:0];
    rn1     = RW'(rn) + RW'(1);

    col_end  = cn1 >= eff_w;
    col_next = col_end ? '0 : CW'(cn1);
    if (!col_end) begin
      row_next = rn;
    end else if (rn1 >= RW'(eff_h)) begin
      row_next = '0;
    end else begin
      row_next = rn1[CFG_W-1:0];
    end

    flags_next.produce  = rn != '0;
    flags_next.interior = (rn >= CFG_W'(2)) && (cn != '0) &&
                          (cn_ext + EW'(2) <= eff_w);
    flags_next.last_row = rn == eff_h - CFG_W'(1);
    flags_next.last_col = cn1 == eff_w;
  end

  // handshake
  assign s1_go        = s1_valid & (~out_valid | res_out.ready);
  assign pix_in.ready = ~s1_valid | s1_go;
  assign acc          = pix_in.valid & pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // line stores
  always_ff @(posedge clk) begin
    if (acc) begin
      prev_row[cn] <= pix_in.pixel;
      above_rd     <= prev_row[cn];
      right_rd     <= prev_row[cn_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      prev2_row[s1_col] <= above_rd;
    end
    if (acc) begin
      above2_rd <= prev2_row[cn];
    end
  end

  // same-column write and read in one cycle (width of one)
  always_ff @(posedge clk) begin
    if (acc) begin
      sp_byp      <= s1_go && (s1_col == cn);
      sp_byp_data <= above_rd;
    end
  end

  assign above2 = sp_byp ? sp_byp_data : above2_rd;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px    <= pix_in.pixel;
      s1_col   <= cn;
      s1_flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_center <= '0;
    end else if (s1_go) begin
      win_center <= above_rd;
    end
  end

  lsh_kernel u_kernel (
    .flags  (s1_flags),
    .above  (above_rd),
    .above2 (above2),
    .left   (win_center),
    .right  (right_rd),
    .px     (s1_px),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_flags.produce;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_res <= res;
    end
  end

  assign res_out.valid            = out_valid;
  assign res_out.upper_pixel      = out_res.upper_pixel;
  assign res_out.bottom_row_pixel = out_res.bottom_row_pixel;
  assign res_out.bottom_row_valid = out_res.bottom_row_valid;
  assign res_out.frame_done       = out_res.frame_done;

endmodule
`default_nettype wire

>>> rtl/lsh_checker.sv
// port-level checks for the laplacian sharpen block, bound to the top level
`default_nettype none
module lsh_checker (
  input wire       clk,
  input wire       rst,
  input wire       pready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] upper_pixel,
  input wire [7:0] bottom_row_pixel,
  input wire       bottom_row_valid,
  input wire       frame_done
);

  // stalled beat stays valid and keeps its pixels and frame_done
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(upper_pixel) &&
      $stable(bottom_row_pixel) && $stable(frame_done))
    else $error("result beat changed while stalled");

  a_copy_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bottom_row_valid |-> bottom_row_pixel == 8'd0)
    else $error("bottom row copy set outside last row");

  a_done_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> bottom_row_valid)
    else $error("frame done outside last row");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && pready)
    else $error("result valid right after reset");

endmodule

bind laplacian_sharpen_3x3 lsh_checker u_lsh_checker (
  .clk              (clk),
  .rst              (rst),
  .pready           (pready),
  .out_valid        (res_out.valid),
  .out_ready        (res_out.ready),
  .upper_pixel      (res_out.upper_pixel),
  .bottom_row_pixel (res_out.bottom_row_pixel),
  .bottom_row_valid (res_out.bottom_row_valid),
  .frame_done       (res_out.frame_done)
);
`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the 3x3 laplacian sharpen block
`timescale 1ns / 1ps
module testbench;
  import lsh_pkg::*;

  localparam int MAX_W          = 2048;
  localparam int FILL_W         = 12;
  localparam int RANDOM_ITEMS   = 900;
  localparam int CALM_ITEMS     = 150;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  class sharpen_scoreboard;
    pixel_t            line_above[MAX_W];
    pixel_t            line_above2[MAX_W];
    pixel_t            win_left;
    pixel_t            win_center;
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    lsh_result_t       sharpened_beats[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      foreach (line_above[i]) begin
        line_above[i]  = '0;
        line_above2[i] = '0;
      end
      win_left   = '0;
      win_center = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors     = 0;
      checked    = 0;
    endfunction

    function int unsigned outstanding();
      return sharpened_beats.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // predicts the result caused by one accepted pixel
    function void take_pixel(pixel_t px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      pixel_t      up2;
      pixel_t      up;
      pixel_t      rt;
      int          v;
      lsh_result_t res;
      w = width_reg;
      if (w > MAX_W) w = MAX_W;
      if (w == 0) w = 1;
      h = (height_reg == 0) ? 1 : height_reg;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      if (c == 0) win_center = '0;
      up2 = line_above2[c];
      up  = line_above[c];
      rt  = (c + 1 < w) ? line_above[c+1] : '0;
      win_left   = win_center;
      win_center = up;
      if (r >= 1) begin
        if (r >= 2 && c >= 1 && c + 1 < w) begin
          v = 5 * int'(up) - (int'(up2) + int'(win_left) + int'(rt) + int'(px));
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          res.upper_pixel = pixel_t'(v);
        end else begin
          res.upper_pixel = up;
        end
        if (r == h - 1) begin
          res.bottom_row_pixel = px;
          res.bottom_row_valid = 1'b1;
          res.frame_done       = (c == w - 1);
        end else begin
          res.bottom_row_pixel = '0;
          res.bottom_row_valid = 1'b0;
          res.frame_done       = 1'b0;
        end
        sharpened_beats.insert(sharpened_beats.size(), res);
      end
      line_above2[c] = up;
      line_above[c]  = px;
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_result(lsh_result_t got);
      lsh_result_t want;
      checked++;
      if (sharpened_beats.size() == 0) begin
        flag($sformatf("result beat %0d with nothing expected: up=%0d bottom=%0d/%0b done=%0b",
                       checked, got.upper_pixel, got.bottom_row_pixel,
                       got.bottom_row_valid, got.frame_done));
        return;
      end
      want = sharpened_beats.pop_front();
      if (got.upper_pixel !== want.upper_pixel ||
          got.bottom_row_pixel !== want.bottom_row_pixel ||
          got.bottom_row_valid !== want.bottom_row_valid ||
          got.frame_done !== want.frame_done)
        flag($sformatf({"result beat %0d: expected up=%0d bottom=%0d/%0b done=%0b,",
                        " got up=%0d bottom=%0d/%0b done=%0b"},
                       checked, want.upper_pixel, want.bottom_row_pixel,
                       want.bottom_row_valid, want.frame_done, got.upper_pixel,
                       got.bottom_row_pixel, got.bottom_row_valid, got.frame_done));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lsh_in_if  pix_in();
  lsh_out_if res_out();

  sharpen_scoreboard sb;

  bit          calm;
  bit          hold_req;
  bit          hold_taken;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned quiet_cycles = 0;

  laplacian_sharpen_3x3 #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pix_in(pix_in),
    .res_out(res_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pixel_t rand_pixel();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return pixel_t'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 45;
    endcase
  endfunction

  task automatic reg_write(input logic idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[CFG_W-1:0] !== value)
      sb.flag($sformatf("register read at %0d: expected %0d, got %0d",
                        {idx, 2'b00}, value, prdata[CFG_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_check(REG_IMAGE_WIDTH, w);
    reg_check(REG_IMAGE_HEIGHT, h);
    sb.width_reg  = w;
    sb.height_reg = h;
  endtask

  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    if (!calm && $urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(13, 1);
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.pixel <= px;
    do @(posedge clk); while (!pix_in.ready);
    sb.take_pixel(px);
  endtask

  // drain every expected beat, then give the pipeline time to go quiet
  task automatic settle();
    pix_in.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result sink with random and long stalls
  initial begin
    int unsigned stall_left;
    lsh_result_t got;
    stall_left = 0;
    res_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_out.valid && res_out.ready) begin
        got.upper_pixel      = res_out.upper_pixel;
        got.bottom_row_pixel = res_out.bottom_row_pixel;
        got.bottom_row_valid = res_out.bottom_row_valid;
        got.frame_done       = res_out.frame_done;
        sb.check_result(got);
      end
      if (stall_left != 0) begin
        stall_left--;
        res_out.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        res_out.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < snk_idle_pct) begin
        stall_left = $urandom_range(12, 0);
        res_out.ready <= 1'b0;
      end else begin
        res_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (res_out.valid && res_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned      n;
    int unsigned      random_items;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    bit               first_phase;
    sb = new();
    calm         = 1'b0;
    hold_req     = 1'b0;
    src_idle_pct = 10;
    snk_idle_pct = 10;
    pix_in.valid <= 1'b0;
    pix_in.pixel <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    rst          <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one frame at the widest geometry used below fills both line stores
    set_geometry(CFG_W'(FILL_W), 12'd2);
    repeat (2 * FILL_W) send_pixel(rand_pixel());
    settle();

    // smallest frame with an interior pixel: dark cross, bright cross, unsaturated center
    set_geometry(12'd3, 12'd3);
    for (int f = 0; f < 3; f++)
      for (int k = 0; k < 9; k++)
        send_pixel(f == 2 ? ((k == 4) ? 8'd60 : 8'd50)
                          : (((k % 2) ^ f) != 0 ? 8'd255 : 8'd0));

    random_items = 0;
    first_phase  = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(9))
        0: begin
          w = CFG_W'($urandom_range(2, 0));
          h = CFG_W'($urandom_range(6, 3));
        end
        1: begin
          w = CFG_W'($urandom_range(8, 3));
          h = CFG_W'($urandom_range(2, 0));
        end
        2: begin
          w = CFG_W'(FILL_W);
          h = CFG_W'($urandom_range(3, 2));
        end
        3: begin
          w = CFG_W'($urandom_range(5, 3));
          h = $urandom_range(1) ? 12'd4095 : 12'd3000;
        end
        default: begin
          w = CFG_W'($urandom_range(10, 3));
          h = CFG_W'($urandom_range(8, 3));
        end
      endcase
      n = $urandom_range(90, 20);
      src_idle_pct = pick_idle_pct();
      snk_idle_pct = pick_idle_pct();
      if (first_phase) begin
        w = 12'd7;
        h = 12'd6;
        n = 120;
      end
      calm = (random_items + CALM_ITEMS >= RANDOM_ITEMS);
      set_geometry(w, h);
      // long sink hold while pixels keep coming, so the input backs up
      if (first_phase) hold_req = 1'b1;
      first_phase = 1'b0;
      for (int k = 0; k < n; k++) send_pixel(rand_pixel());
      random_items += n;
    end

    pix_in.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
